### sv/thrc_pkg.sv
// ----------------------------------------------------------------------------
// thrc_pkg
// shared constants, register codes, state encoding and the command and
// status structs of the thresholded centroid block
// ----------------------------------------------------------------------------
package thrc_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int FRACTION_BITS = 8;

    localparam int PIX_W    = 8;
    localparam int DIM_W    = 13;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int SUM_W    = 36;
    localparam int CNT_W    = 25;
    localparam int CENTER_W = 20;
    localparam int DVD_W    = SUM_W + FRACTION_BITS;
    localparam int STEP_W   = $clog2(DVD_W);
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [PIX_W-1:0] RESET_THRESHOLD = 8'h80;
    localparam logic [DIM_W-1:0] RESET_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT    = 13'd480;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2,
        REG_NONE      = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        S_ACC = 3'b001,
        S_DIV = 3'b010,
        S_OUT = 3'b100
    } state_t;

    typedef struct packed {
        logic [PIX_W-1:0] threshold;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic capture;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic out_busy;
    } status_t;

endpackage

### sv/thrc_regs.sv
// ----------------------------------------------------------------------------
// thrc_regs
// apb register bank holding threshold and frame size; gives the clamped
// frame dimensions to the datapath
// ----------------------------------------------------------------------------
module thrc_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [thrc_pkg::DATA_W-1:0]   pwdata,
    output logic [thrc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output thrc_pkg::cfg_t                cfg
);

    logic [thrc_pkg::PIX_W-1:0] threshold_reg, threshold_next;
    logic [thrc_pkg::DIM_W-1:0] width_reg, width_next;
    logic [thrc_pkg::DIM_W-1:0] height_reg, height_next;
    thrc_pkg::reg_index_t       index;
    logic                       wr_en;

    assign pready = 1'b1;
    assign index  = thrc_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        threshold_next = threshold_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        if (wr_en)
        begin
            unique case (index)
                thrc_pkg::REG_THRESHOLD: threshold_next = pwdata[thrc_pkg::PIX_W-1:0];
                thrc_pkg::REG_WIDTH:     width_next     = pwdata[thrc_pkg::DIM_W-1:0];
                thrc_pkg::REG_HEIGHT:    height_next    = pwdata[thrc_pkg::DIM_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= thrc_pkg::RESET_THRESHOLD;
            width_reg     <= thrc_pkg::RESET_WIDTH;
            height_reg    <= thrc_pkg::RESET_HEIGHT;
        end
        else
        begin
            threshold_reg <= threshold_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    always_comb
    begin
        unique case (index)
            thrc_pkg::REG_THRESHOLD: prdata = thrc_pkg::DATA_W'(threshold_reg);
            thrc_pkg::REG_WIDTH:     prdata = thrc_pkg::DATA_W'(width_reg);
            thrc_pkg::REG_HEIGHT:    prdata = thrc_pkg::DATA_W'(height_reg);
            default:                 prdata = '0;
        endcase
    end

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        cfg.threshold = threshold_reg;
        priority if (width_reg == '0)
            cfg.width = thrc_pkg::DIM_W'(1);
        else if (width_reg > thrc_pkg::DIM_W'(thrc_pkg::MAX_WIDTH))
            cfg.width = thrc_pkg::DIM_W'(thrc_pkg::MAX_WIDTH);
        else
            cfg.width = width_reg;
        priority if (height_reg == '0)
            cfg.height = thrc_pkg::DIM_W'(1);
        else if (height_reg > thrc_pkg::DIM_W'(thrc_pkg::MAX_HEIGHT))
            cfg.height = thrc_pkg::DIM_W'(thrc_pkg::MAX_HEIGHT);
        else
            cfg.height = height_reg;
    end

endmodule

### sv/thrc_ctrl.sv
// ----------------------------------------------------------------------------
// thrc_ctrl
// controller: accumulate pixels, sequence the bit-serial divide, hand the
// result to the output register
// ----------------------------------------------------------------------------
module thrc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  thrc_pkg::status_t status,
    output thrc_pkg::cmd_t    cmd
);

    thrc_pkg::state_t            state_reg, state_next;
    logic [thrc_pkg::STEP_W-1:0] step_reg, step_next;

    assign in_stall     = (state_reg != thrc_pkg::S_ACC);
    assign cmd.accept   = in_valid & (state_reg == thrc_pkg::S_ACC);
    assign cmd.capture  = cmd.accept & status.frame_end;
    assign cmd.div_step = (state_reg == thrc_pkg::S_DIV);
    assign cmd.load_out = (state_reg == thrc_pkg::S_OUT) & ~status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            thrc_pkg::S_ACC:
            begin
                step_next = '0;
                if (cmd.capture)
                    state_next = thrc_pkg::S_DIV;
            end
            thrc_pkg::S_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == thrc_pkg::STEP_W'(thrc_pkg::DVD_W - 1))
                    state_next = thrc_pkg::S_OUT;
            end
            thrc_pkg::S_OUT:
            begin
                if (cmd.load_out)
                    state_next = thrc_pkg::S_ACC;
            end
            default:
            begin
                state_next = thrc_pkg::S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= thrc_pkg::S_ACC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### sv/thrc_dp.sv
// ----------------------------------------------------------------------------
// thrc_dp
// datapath: raster counters, column and row sums, bright tally, two
// restoring dividers sharing one divisor, output register
// ----------------------------------------------------------------------------
module thrc_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  thrc_pkg::cfg_t                  cfg,
    input  logic [thrc_pkg::PIX_W-1:0]      pixel,
    input  thrc_pkg::cmd_t                  cmd,
    output thrc_pkg::status_t               status,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [thrc_pkg::CENTER_W-1:0]   center_x,
    output logic [thrc_pkg::CENTER_W-1:0]   center_y,
    output logic [thrc_pkg::CNT_W-1:0]      bright_count,
    output logic                            empty_frame
);

    localparam int CNT_W = thrc_pkg::CNT_W;
    localparam int DVD_W = thrc_pkg::DVD_W;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [DVD_W-1:0] dq;
    } div_t;

    logic [thrc_pkg::COL_W-1:0]    col_reg, col_next;
    logic [thrc_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [thrc_pkg::SUM_W-1:0]    col_sum_reg, col_sum_next, col_sum_add;
    logic [thrc_pkg::SUM_W-1:0]    row_sum_reg, row_sum_next, row_sum_add;
    logic [CNT_W-1:0]              tally_reg, tally_next, tally_add;
    logic                          hit, row_end, frame_end;

    div_t                          xdiv_reg, xdiv_next, ydiv_reg, ydiv_next;
    logic [CNT_W-1:0]              divisor_reg, divisor_next;
    logic                          empty_reg, empty_next;

    logic                          out_valid_reg, out_valid_next;
    logic [thrc_pkg::CENTER_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          oempty_reg, oempty_next;

    function automatic div_t div_step(input div_t d, input logic [CNT_W-1:0] divisor);
        logic [CNT_W:0] rem_sh;
        logic [CNT_W:0] diff;
        logic           ge;
        div_t           r;
        rem_sh = {d.rem, d.dq[DVD_W-1]};
        diff   = rem_sh - {1'b0, divisor};
        ge     = (rem_sh >= {1'b0, divisor});
        r.rem  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        r.dq   = {d.dq[DVD_W-2:0], ge};
        return r;
    endfunction

    assign hit         = (pixel > cfg.threshold);
    assign col_sum_add = col_sum_reg + (hit ? thrc_pkg::SUM_W'(col_reg) : '0);
    assign row_sum_add = row_sum_reg + (hit ? thrc_pkg::SUM_W'(row_reg) : '0);
    assign tally_add   = tally_reg + (hit ? CNT_W'(1) : '0);
    assign row_end     = (thrc_pkg::DIM_W'(col_reg) + 1'b1) >= cfg.width;
    assign frame_end   = row_end & ((thrc_pkg::DIM_W'(row_reg) + 1'b1) >= cfg.height);

    assign status.frame_end = frame_end;
    assign status.out_busy  = out_valid_reg & out_stall;

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        tally_next   = tally_reg;
        xdiv_next    = xdiv_reg;
        ydiv_next    = ydiv_reg;
        divisor_next = divisor_reg;
        empty_next   = empty_reg;
        if (cmd.accept)
        begin
            priority if (frame_end)
            begin
                col_next     = '0;
                row_next     = '0;
                col_sum_next = '0;
                row_sum_next = '0;
                tally_next   = '0;
            end
            else if (row_end)
            begin
                col_next     = '0;
                row_next     = row_reg + 1'b1;
                col_sum_next = col_sum_add;
                row_sum_next = row_sum_add;
                tally_next   = tally_add;
            end
            else
            begin
                col_next     = col_reg + 1'b1;
                col_sum_next = col_sum_add;
                row_sum_next = row_sum_add;
                tally_next   = tally_add;
            end
        end
        if (cmd.capture)
        begin
            xdiv_next.rem = '0;
            xdiv_next.dq  = {col_sum_add, {thrc_pkg::FRACTION_BITS{1'b0}}};
            ydiv_next.rem = '0;
            ydiv_next.dq  = {row_sum_add, {thrc_pkg::FRACTION_BITS{1'b0}}};
            divisor_next  = tally_add;
            empty_next    = (tally_add == '0);
        end
        else if (cmd.div_step)
        begin
            xdiv_next = div_step(xdiv_reg, divisor_reg);
            ydiv_next = div_step(ydiv_reg, divisor_reg);
        end
    end

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cnt_next    = cnt_reg;
        oempty_next = oempty_reg;
        if (cmd.load_out)
        begin
            cx_next        = empty_reg ? '0 : xdiv_reg.dq[thrc_pkg::CENTER_W-1:0];
            cy_next        = empty_reg ? '0 : ydiv_reg.dq[thrc_pkg::CENTER_W-1:0];
            cnt_next       = divisor_reg;
            oempty_next    = empty_reg;
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            col_sum_reg   <= '0;
            row_sum_reg   <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_sum_reg   <= col_sum_next;
            row_sum_reg   <= row_sum_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xdiv_reg    <= xdiv_next;
        ydiv_reg    <= ydiv_next;
        divisor_reg <= divisor_next;
        empty_reg   <= empty_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cnt_reg     <= cnt_next;
        oempty_reg  <= oempty_next;
    end

    assign out_valid    = out_valid_reg;
    assign center_x     = cx_reg;
    assign center_y     = cy_reg;
    assign bright_count = cnt_reg;
    assign empty_frame  = oempty_reg;

endmodule

### sv/thresholded_centroid.sv
// ----------------------------------------------------------------------------
// thresholded_centroid
// one pixel word per cycle while a frame streams in and input is not stalled; the last
// pixel starts a restoring divide (one quotient bit per cycle, both axes at once)
// during which input is stalled; input stays stalled until the result word is
// loaded into the output register, which waits while a held result is stalled
// reset clears counters, sums and output valid; registers return to 128/640/480
// ----------------------------------------------------------------------------
module thresholded_centroid
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [thrc_pkg::ADDR_W-1:0]     paddr,
    input  logic [thrc_pkg::DATA_W-1:0]     pwdata,
    output logic [thrc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [thrc_pkg::PIX_W-1:0]      pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [thrc_pkg::CENTER_W-1:0]   center_x,
    output logic [thrc_pkg::CENTER_W-1:0]   center_y,
    output logic [thrc_pkg::CNT_W-1:0]      bright_count,
    output logic                            empty_frame
);

    thrc_pkg::cfg_t    cfg;
    thrc_pkg::cmd_t    cmd;
    thrc_pkg::status_t status;

    thrc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thrc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    thrc_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pixel        (pixel),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .center_x     (center_x),
        .center_y     (center_y),
        .bright_count (bright_count),
        .empty_frame  (empty_frame)
    );

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result load did not raise out_valid");

    a_div_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> in_stall)
        else $error("input taken during divide");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> center_x == '0 && center_y == '0 && bright_count == '0)
        else $error("empty frame word carries nonzero fields");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_frame |-> bright_count != '0)
        else $error("non-empty frame word with zero count");

endmodule
